>>> design/nlc_pkg.sv
// nlc_pkg: shared types and character constants for the numeric literal classifier.
// No dependencies; used by every module in the design folder.
package nlc_pkg;

  localparam logic [7:0] CharPlus  = 8'h2B;  // '+'
  localparam logic [7:0] CharMinus = 8'h2D;  // '-'
  localparam logic [7:0] CharPoint = 8'h2E;  // '.'
  localparam logic [7:0] CharExpUp = 8'h45;  // 'E'
  localparam logic [7:0] CharExpLo = 8'h65;  // 'e'
  localparam logic [7:0] CharLpar  = 8'h28;  // '('
  localparam logic [7:0] CharRpar  = 8'h29;  // ')'
  localparam logic [7:0] CharZero  = 8'h30;  // '0'
  localparam logic [7:0] CharNine  = 8'h39;  // '9'

  // Decoded character class, shared by both recognizers
  typedef struct packed {
    logic digit;
    logic sign;
    logic point;
    logic exp_mark;
    logic lpar;
    logic rpar;
  } char_class_t;

  typedef enum logic [2:0] {
    I_START,
    I_SIGN,
    I_DIGITS,
    I_LPAR,
    I_UDIGITS,
    I_CLOSED,
    I_DEAD
  } int_phase_t;

  typedef enum logic [3:0] {
    R_START,
    R_SIGN,
    R_LPOINT,
    R_IDIGITS,
    R_TPOINT,
    R_FDIGITS,
    R_EMARK,
    R_ESIGN,
    R_EDIGITS,
    R_LPAR,
    R_UDIGITS,
    R_CLOSED,
    R_DEAD
  } real_phase_t;

endpackage

>>> design/nlc_char_class.sv
// nlc_char_class: decodes one ASCII byte into the class flags the recognizers use.
// Depends on nlc_pkg.
module nlc_char_class (
  input  logic [7:0]          character,
  output nlc_pkg::char_class_t cls
);

  always_comb begin
    cls.digit    = (character >= nlc_pkg::CharZero) && (character <= nlc_pkg::CharNine);
    cls.sign     = (character == nlc_pkg::CharPlus) || (character == nlc_pkg::CharMinus);
    cls.point    = (character == nlc_pkg::CharPoint);
    cls.exp_mark = (character == nlc_pkg::CharExpUp) || (character == nlc_pkg::CharExpLo);
    cls.lpar     = (character == nlc_pkg::CharLpar);
    cls.rpar     = (character == nlc_pkg::CharRpar);
  end

endmodule

>>> design/nlc_int_dfa.sv
// nlc_int_dfa: integer recognizer, state register plus transition logic.
// Depends on nlc_pkg.
module nlc_int_dfa (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,      // consume one character
  input  logic                last,      // token ends with this character
  input  nlc_pkg::char_class_t cls,
  output logic                accept     // verdict after this character
);

  nlc_pkg::int_phase_t phase, phase_step, phase_next;

  always_comb begin
    unique case (phase)
      nlc_pkg::I_START:
        phase_step = cls.digit ? nlc_pkg::I_DIGITS :
                     cls.sign  ? nlc_pkg::I_SIGN : nlc_pkg::I_DEAD;
      nlc_pkg::I_SIGN:
        phase_step = cls.digit ? nlc_pkg::I_DIGITS : nlc_pkg::I_DEAD;
      nlc_pkg::I_DIGITS:
        phase_step = cls.digit ? nlc_pkg::I_DIGITS :
                     cls.lpar  ? nlc_pkg::I_LPAR : nlc_pkg::I_DEAD;
      nlc_pkg::I_LPAR:
        phase_step = cls.digit ? nlc_pkg::I_UDIGITS : nlc_pkg::I_DEAD;
      nlc_pkg::I_UDIGITS:
        phase_step = cls.digit ? nlc_pkg::I_UDIGITS :
                     cls.rpar  ? nlc_pkg::I_CLOSED : nlc_pkg::I_DEAD;
      default:
        phase_step = nlc_pkg::I_DEAD;
    endcase

    accept = (phase_step == nlc_pkg::I_DIGITS) || (phase_step == nlc_pkg::I_CLOSED);

    phase_next = phase;
    if (step) begin
      phase_next = last ? nlc_pkg::I_START : phase_step;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= nlc_pkg::I_START;
    end else begin
      phase <= phase_next;
    end
  end

endmodule

>>> design/nlc_real_dfa.sv
// nlc_real_dfa: real-number recognizer, state register plus transition logic.
// Depends on nlc_pkg.
module nlc_real_dfa (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  logic                last,
  input  nlc_pkg::char_class_t cls,
  output logic                accept
);

  nlc_pkg::real_phase_t phase, phase_step, phase_next, tail;

  always_comb begin
    // after a complete mantissa: exponent or uncertainty may follow
    tail = cls.exp_mark ? nlc_pkg::R_EMARK :
           cls.lpar     ? nlc_pkg::R_LPAR : nlc_pkg::R_DEAD;

    unique case (phase)
      nlc_pkg::R_START:
        phase_step = cls.digit ? nlc_pkg::R_IDIGITS :
                     cls.sign  ? nlc_pkg::R_SIGN :
                     cls.point ? nlc_pkg::R_LPOINT : nlc_pkg::R_DEAD;
      nlc_pkg::R_SIGN:
        phase_step = cls.digit ? nlc_pkg::R_IDIGITS :
                     cls.point ? nlc_pkg::R_LPOINT : nlc_pkg::R_DEAD;
      nlc_pkg::R_LPOINT:
        phase_step = cls.digit ? nlc_pkg::R_FDIGITS : nlc_pkg::R_DEAD;
      nlc_pkg::R_IDIGITS:
        phase_step = cls.digit ? nlc_pkg::R_IDIGITS :
                     cls.point ? nlc_pkg::R_TPOINT : tail;
      nlc_pkg::R_TPOINT, nlc_pkg::R_FDIGITS:
        phase_step = cls.digit ? nlc_pkg::R_FDIGITS : tail;
      nlc_pkg::R_EMARK:
        phase_step = cls.digit ? nlc_pkg::R_EDIGITS :
                     cls.sign  ? nlc_pkg::R_ESIGN : nlc_pkg::R_DEAD;
      nlc_pkg::R_ESIGN:
        phase_step = cls.digit ? nlc_pkg::R_EDIGITS : nlc_pkg::R_DEAD;
      nlc_pkg::R_EDIGITS:
        phase_step = cls.digit ? nlc_pkg::R_EDIGITS :
                     cls.lpar  ? nlc_pkg::R_LPAR : nlc_pkg::R_DEAD;
      nlc_pkg::R_LPAR:
        phase_step = cls.digit ? nlc_pkg::R_UDIGITS : nlc_pkg::R_DEAD;
      nlc_pkg::R_UDIGITS:
        phase_step = cls.digit ? nlc_pkg::R_UDIGITS :
                     cls.rpar  ? nlc_pkg::R_CLOSED : nlc_pkg::R_DEAD;
      default:
        phase_step = nlc_pkg::R_DEAD;
    endcase

    accept = (phase_step == nlc_pkg::R_IDIGITS) || (phase_step == nlc_pkg::R_TPOINT) ||
             (phase_step == nlc_pkg::R_FDIGITS) || (phase_step == nlc_pkg::R_EDIGITS) ||
             (phase_step == nlc_pkg::R_CLOSED);

    phase_next = phase;
    if (step) begin
      phase_next = last ? nlc_pkg::R_START : phase_step;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= nlc_pkg::R_START;
    end else begin
      phase <= phase_next;
    end
  end

endmodule

>>> design/numeric_literal_classifier.sv
// Numeric literal classifier: feed a token one byte per transfer on the character
// channel, with last_char set on its final byte. Each token yields exactly one
// verdict transfer (integer_ok, real_ok); bytes without last_char yield none. Rate:
// one byte per cycle sustained unless a final byte stalls on the verdict channel.
// Bytes sit in an input register, then both recognizers step in the same cycle
// as the byte moves on; the verdict lands in an output register. A non-final
// byte never waits on the verdict channel, so only a final byte can stall behind
// an untaken verdict.
//
// Depends on nlc_pkg, nlc_char_class, nlc_int_dfa, nlc_real_dfa.
module numeric_literal_classifier (
  input  logic       clk,
  input  logic       rst,
  // character channel
  input  logic       char_valid,
  output logic       char_ready,
  input  logic [7:0] character,
  input  logic       last_char,
  // verdict channel
  output logic       verdict_valid,
  input  logic       verdict_ready,
  output logic       integer_ok,
  output logic       real_ok
);

  // input register stage
  logic       in_valid;
  logic [7:0] in_char;
  logic       in_last;

  logic                 step;      // registered byte consumed by the recognizers
  logic                 out_free;  // verdict register can take a new value
  logic                 int_acc, real_acc;
  nlc_pkg::char_class_t cls;

  assign out_free   = !verdict_valid || verdict_ready;
  assign step       = in_valid && (!in_last || out_free);
  assign char_ready = !in_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (char_ready) begin
      in_valid <= char_valid;
    end
  end

  // payload only, no reset needed
  always_ff @(posedge clk) begin
    if (char_valid && char_ready) begin
      in_char <= character;
      in_last <= last_char;
    end
  end

  nlc_char_class u_class (
    .character (in_char),
    .cls       (cls)
  );

  nlc_int_dfa u_int (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .last   (in_last),
    .cls    (cls),
    .accept (int_acc)
  );

  nlc_real_dfa u_real (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .last   (in_last),
    .cls    (cls),
    .accept (real_acc)
  );

  // verdict register: loads on the final byte of a token
  always_ff @(posedge clk) begin
    if (rst) begin
      verdict_valid <= 1'b0;
    end else if (step && in_last) begin
      verdict_valid <= 1'b1;
    end else if (verdict_ready) begin
      verdict_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && in_last) begin
      integer_ok <= int_acc;
      real_ok    <= real_acc;
    end
  end

endmodule

>>> verif/tb.sv
// tb: self-checking bench for numeric_literal_classifier, with a verdict scoreboard class.
// Depends on nlc_pkg and the numeric_literal_classifier RTL; drives tokens byte by byte.
`timescale 1ns / 1ps

module tb;

  localparam int CYCLE_LIMIT  = 200000;  // far above the slowest legal run
  localparam int HOLD_CYCLES  = 300;     // long verdict back-pressure window
  localparam int DRAIN_CYCLES = 10;      // margin after the last verdict lands
  localparam int PHASE_CHARS  = 600;     // three idle phases, ~1800 bytes total

  typedef logic [7:0] char_q_t[$];

  typedef struct packed {
    logic integer_ok;
    logic real_ok;
  } verdict_t;

  // Scoreboard: tracks both recognizers on every accepted byte and queues the
  // verdict that each final byte should produce.
  class verdict_board;
    nlc_pkg::int_phase_t  int_track;
    nlc_pkg::real_phase_t real_track;
    verdict_t             due[$];
    int                   errors;
    int                   verdicts_seen;

    function new();
      int_track     = nlc_pkg::I_START;
      real_track    = nlc_pkg::R_START;
      errors        = 0;
      verdicts_seen = 0;
    endfunction

    function bit is_digit(logic [7:0] c);
      return c >= nlc_pkg::CharZero && c <= nlc_pkg::CharNine;
    endfunction

    function bit is_sign(logic [7:0] c);
      return c == nlc_pkg::CharPlus || c == nlc_pkg::CharMinus;
    endfunction

    function nlc_pkg::int_phase_t next_int(nlc_pkg::int_phase_t s, logic [7:0] c);
      case (s)
        nlc_pkg::I_START: begin
          if (is_digit(c)) return nlc_pkg::I_DIGITS;
          return is_sign(c) ? nlc_pkg::I_SIGN : nlc_pkg::I_DEAD;
        end
        nlc_pkg::I_SIGN:
          return is_digit(c) ? nlc_pkg::I_DIGITS : nlc_pkg::I_DEAD;
        nlc_pkg::I_DIGITS: begin
          if (is_digit(c)) return nlc_pkg::I_DIGITS;
          return c == nlc_pkg::CharLpar ? nlc_pkg::I_LPAR : nlc_pkg::I_DEAD;
        end
        nlc_pkg::I_LPAR:
          return is_digit(c) ? nlc_pkg::I_UDIGITS : nlc_pkg::I_DEAD;
        nlc_pkg::I_UDIGITS: begin
          if (is_digit(c)) return nlc_pkg::I_UDIGITS;
          return c == nlc_pkg::CharRpar ? nlc_pkg::I_CLOSED : nlc_pkg::I_DEAD;
        end
        default: return nlc_pkg::I_DEAD;
      endcase
    endfunction

    // once the mantissa may end, only an exponent or an uncertainty can follow
    function nlc_pkg::real_phase_t after_mantissa(logic [7:0] c);
      if (c == nlc_pkg::CharExpUp || c == nlc_pkg::CharExpLo) return nlc_pkg::R_EMARK;
      if (c == nlc_pkg::CharLpar) return nlc_pkg::R_LPAR;
      return nlc_pkg::R_DEAD;
    endfunction

    function nlc_pkg::real_phase_t next_real(nlc_pkg::real_phase_t s, logic [7:0] c);
      case (s)
        nlc_pkg::R_START: begin
          if (is_digit(c)) return nlc_pkg::R_IDIGITS;
          if (is_sign(c)) return nlc_pkg::R_SIGN;
          return c == nlc_pkg::CharPoint ? nlc_pkg::R_LPOINT : nlc_pkg::R_DEAD;
        end
        nlc_pkg::R_SIGN: begin
          if (is_digit(c)) return nlc_pkg::R_IDIGITS;
          return c == nlc_pkg::CharPoint ? nlc_pkg::R_LPOINT : nlc_pkg::R_DEAD;
        end
        nlc_pkg::R_LPOINT:
          return is_digit(c) ? nlc_pkg::R_FDIGITS : nlc_pkg::R_DEAD;
        nlc_pkg::R_IDIGITS: begin
          if (is_digit(c)) return nlc_pkg::R_IDIGITS;
          if (c == nlc_pkg::CharPoint) return nlc_pkg::R_TPOINT;
          return after_mantissa(c);
        end
        nlc_pkg::R_TPOINT, nlc_pkg::R_FDIGITS:
          return is_digit(c) ? nlc_pkg::R_FDIGITS : after_mantissa(c);
        nlc_pkg::R_EMARK: begin
          if (is_digit(c)) return nlc_pkg::R_EDIGITS;
          return is_sign(c) ? nlc_pkg::R_ESIGN : nlc_pkg::R_DEAD;
        end
        nlc_pkg::R_ESIGN:
          return is_digit(c) ? nlc_pkg::R_EDIGITS : nlc_pkg::R_DEAD;
        nlc_pkg::R_EDIGITS: begin
          if (is_digit(c)) return nlc_pkg::R_EDIGITS;
          return c == nlc_pkg::CharLpar ? nlc_pkg::R_LPAR : nlc_pkg::R_DEAD;
        end
        nlc_pkg::R_LPAR:
          return is_digit(c) ? nlc_pkg::R_UDIGITS : nlc_pkg::R_DEAD;
        nlc_pkg::R_UDIGITS: begin
          if (is_digit(c)) return nlc_pkg::R_UDIGITS;
          return c == nlc_pkg::CharRpar ? nlc_pkg::R_CLOSED : nlc_pkg::R_DEAD;
        end
        default: return nlc_pkg::R_DEAD;
      endcase
    endfunction

    function void note_char(logic [7:0] c, logic last);
      verdict_t v;
      int_track  = next_int(int_track, c);
      real_track = next_real(real_track, c);
      if (last) begin
        v.integer_ok = (int_track == nlc_pkg::I_DIGITS || int_track == nlc_pkg::I_CLOSED);
        v.real_ok    = (real_track == nlc_pkg::R_IDIGITS ||
                        real_track == nlc_pkg::R_TPOINT ||
                        real_track == nlc_pkg::R_FDIGITS ||
                        real_track == nlc_pkg::R_EDIGITS ||
                        real_track == nlc_pkg::R_CLOSED);
        due.push_back(v);
        int_track  = nlc_pkg::I_START;
        real_track = nlc_pkg::R_START;
      end
    endfunction

    function int pending();
      return due.size();
    endfunction

    task report(string msg);
      errors++;
      $display("[%0t] ERROR: %s", $time, msg);
    endtask

    task check_verdict(logic int_ok, logic real_ok);
      verdict_t want;
      verdicts_seen++;
      if (due.size() == 0) begin
        report($sformatf("verdict %0d arrived with no token pending", verdicts_seen));
        return;
      end
      want = due.pop_front();
      if (int_ok !== want.integer_ok)
        report($sformatf("verdict %0d integer_ok got %b want %b",
                         verdicts_seen, int_ok, want.integer_ok));
      if (real_ok !== want.real_ok)
        report($sformatf("verdict %0d real_ok got %b want %b",
                         verdicts_seen, real_ok, want.real_ok));
    endtask
  endclass

  // DUT ports; every input known from time zero
  logic       clk           = 1'b0;
  logic       rst           = 1'b1;
  logic       char_valid    = 1'b0;
  logic       char_ready;
  logic [7:0] character     = 8'h00;
  logic       last_char     = 1'b0;
  logic       verdict_valid;
  logic       verdict_ready = 1'b0;
  logic       integer_ok;
  logic       real_ok;

  verdict_board board = new();

  // idle percentages for each side, changed per phase by the main sequence
  int send_idle = 0;
  int recv_idle = 0;

  // long verdict hold-off: main bumps stall_orders, receiver serves it
  int stall_orders = 0;
  int stall_served = 0;
  int stall_left   = 0;

  int cycle_count;

  numeric_literal_classifier DUT (
    .clk           (clk),
    .rst           (rst),
    .char_valid    (char_valid),
    .char_ready    (char_ready),
    .character     (character),
    .last_char     (last_char),
    .verdict_valid (verdict_valid),
    .verdict_ready (verdict_ready),
    .integer_ok    (integer_ok),
    .real_ok       (real_ok)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Receiver: ready moves only at the falling edge. A served hold order pins ready
  // low while stall_left counts down from HOLD_CYCLES, so the byte channel backs up behind it.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left    <= stall_left - 1;
      verdict_ready <= 1'b0;
    end else if (stall_served != stall_orders) begin
      stall_served  <= stall_orders;
      stall_left    <= HOLD_CYCLES;
      verdict_ready <= 1'b0;
    end else begin
      verdict_ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // verdict transfers are sampled at the rising edge
  always @(posedge clk) begin
    if (!rst && verdict_valid && verdict_ready)
      board.check_verdict(integer_ok, real_ok);
  end

  // Watchdog: hitting the limit means a hang or a lost verdict.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("numeric_literal_classifier: mismatch");
    $finish;
  end

  // One byte transfer. Called at a falling edge, returns at a falling edge.
  // Valid is either held across back-to-back bytes or dropped for a random
  // gap first; it is never dropped and raised in the same step.
  task automatic send_char(input logic [7:0] c, input logic last);
    while ($urandom_range(99) < send_idle) begin
      char_valid <= 1'b0;
      @(negedge clk);
    end
    char_valid <= 1'b1;
    character  <= c;
    last_char  <= last;
    @(posedge clk);
    while (!char_ready) @(posedge clk);
    board.note_char(c, last);
    @(negedge clk);
  endtask

  task automatic send_token(input char_q_t tok);
    for (int i = 0; i < tok.size(); i++)
      send_char(tok[i], i == tok.size() - 1);
  endtask

  function automatic logic [7:0] rand_digit();
    return nlc_pkg::CharZero + 8'($urandom_range(9));
  endfunction

  function automatic logic [7:0] rand_sign();
    return $urandom_range(1) ? nlc_pkg::CharPlus : nlc_pkg::CharMinus;
  endfunction

  function automatic void add_digits(ref char_q_t t, input int lo, input int hi);
    repeat ($urandom_range(hi, lo)) t.push_back(rand_digit());
  endfunction

  // any byte with a role in the grammar, digits included
  function automatic logic [7:0] rand_mark();
    case ($urandom_range(7))
      0:       return nlc_pkg::CharPlus;
      1:       return nlc_pkg::CharMinus;
      2:       return nlc_pkg::CharPoint;
      3:       return nlc_pkg::CharExpUp;
      4:       return nlc_pkg::CharExpLo;
      5:       return nlc_pkg::CharLpar;
      6:       return nlc_pkg::CharRpar;
      default: return rand_digit();
    endcase
  endfunction

  // Well-formed literal with random content: integer, or real with any of
  // the four mantissa shapes, optional exponent and optional uncertainty.
  function automatic char_q_t make_number(input bit as_real);
    char_q_t t;
    if ($urandom_range(2) == 0) t.push_back(rand_sign());
    if (!as_real) begin
      add_digits(t, 1, 4);
    end else begin
      case ($urandom_range(3))
        0: add_digits(t, 1, 4);
        1: begin
          add_digits(t, 1, 4);
          t.push_back(nlc_pkg::CharPoint);
        end
        2: begin
          add_digits(t, 1, 3);
          t.push_back(nlc_pkg::CharPoint);
          add_digits(t, 1, 3);
        end
        default: begin
          t.push_back(nlc_pkg::CharPoint);
          add_digits(t, 1, 4);
        end
      endcase
      if ($urandom_range(1)) begin
        t.push_back($urandom_range(1) ? nlc_pkg::CharExpUp : nlc_pkg::CharExpLo);
        if ($urandom_range(1)) t.push_back(rand_sign());
        add_digits(t, 1, 3);
      end
    end
    if ($urandom_range(2) == 0) begin
      t.push_back(nlc_pkg::CharLpar);
      add_digits(t, 1, 3);
      t.push_back(nlc_pkg::CharRpar);
    end
    return t;
  endfunction

  // Mostly well-formed tokens; the rest are damaged literals and raw noise.
  function automatic char_q_t make_token();
    char_q_t t;
    int      kind;
    int      pos;
    kind = $urandom_range(99);
    if (kind < 35) begin
      t = make_number(1'b0);
    end else if (kind < 70) begin
      t = make_number(1'b1);
    end else if (kind < 90) begin
      t   = make_number($urandom_range(1));
      pos = $urandom_range(t.size() - 1);
      case ($urandom_range(2))
        0:       t[pos] = 8'($urandom_range(255));
        1:       while (t.size() > pos + 1) void'(t.pop_back());
        default: t.insert(pos, rand_mark());
      endcase
    end else begin
      repeat ($urandom_range(6, 1))
        t.push_back($urandom_range(1) ? 8'($urandom_range(255)) : rand_mark());
    end
    return t;
  endfunction

  initial begin
    string   words[$];
    char_q_t tok;
    int      sent;
    bit      hold_done;

    // directed tokens: lone digit and lone sign, leading and trailing point,
    // signed integer with uncertainty, exponent right after a point, a bare
    // point and a bare exponent mark
    words = '{"9", "-", ".5", "1.", "-0(9)", "1.e-5", ".", "e"};

    repeat (2) @(negedge clk);
    rst <= 1'b0;

    send_idle = 18;
    recv_idle = 73;
    foreach (words[w]) begin
      tok.delete();
      for (int i = 0; i < words[w].len(); i++) tok.push_back(words[w][i]);
      send_token(tok);
    end
    // byte zero and a high byte, each as a one-byte token
    send_char(8'h00, 1'b1);
    send_char(8'hFF, 1'b1);

    hold_done = 1'b0;
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle = 18;
          recv_idle = 73;
        end
        1: begin
          send_idle = 73;
          recv_idle = 18;
        end
        default: begin
          send_idle = 0;
          recv_idle = 0;
        end
      endcase
      sent = 0;
      while (sent < PHASE_CHARS) begin
        tok = make_token();
        send_token(tok);
        sent += tok.size();
        // mid first phase: freeze the verdict side while bytes keep coming
        if (phase == 0 && !hold_done && sent > PHASE_CHARS / 2) begin
          stall_orders++;
          hold_done = 1'b1;
        end
      end
      // after the first phase the sender waits for every verdict to land
      if (phase == 0) begin
        char_valid <= 1'b0;
        while (board.pending() != 0) @(negedge clk);
      end
    end
    char_valid <= 1'b0;

    while (board.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (board.errors == 0)
      $display("numeric_literal_classifier: match");
    else
      $display("numeric_literal_classifier: mismatch");
    $finish;
  end

endmodule

>>> numeric_literal_classifier.f
design/nlc_pkg.sv
design/nlc_char_class.sv
design/nlc_int_dfa.sv
design/nlc_real_dfa.sv
design/numeric_literal_classifier.sv
verif/tb.sv
